[hw/rtl/bubble_sort_engine_core_defines.svh]
// ============================================================================
// bubble_sort_engine_core_defines.svh
// Assertion macros shared by the checker files of the sort engine.
// ============================================================================
`ifndef BUBBLE_SORT_ENGINE_CORE_DEFINES_SVH
`define BUBBLE_SORT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define BSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bse assertion failed");

// Next-cycle implication, disabled while reset is held
`define BSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bse assertion failed");

`endif

[hw/rtl/bse_pkg.sv]
// ============================================================================
// bse_pkg
// Types and constants of the bubble sort engine.
// ============================================================================
package bse_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAX_ITEMS  = 64;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CNT_W-1:0]             t_cnt;

    // Input request
    typedef struct packed {
        t_data value;
        logic  final_item;
    } t_in_req;

    // Output request
    typedef struct packed {
        t_data sorted_value;
        logic  run_end;
        logic  dropped;
    } t_out_req;

    // Element store access from the controller
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_data wdata;
        t_idx  raddr;
    } t_ram_req;

endpackage

[hw/rtl/bse_ram.sv]
// ============================================================================
// bse_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bse_ctrl.sv]
// ============================================================================
// bse_ctrl
// Load, sort and drain sequencer of the bubble sort engine. Each pass carries
// the running maximum in a register: one store read and one write per cycle.
// ============================================================================
module bse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bse_pkg::t_in_req  i_in_req,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output bse_pkg::t_out_req o_out_req,
    input  logic              i_out_stall,
    output bse_pkg::t_ram_req o_ram,
    input  bse_pkg::t_data    i_rdata
);
    import bse_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PRIME,
        S_STEP,
        S_TAIL,
        S_ORD,
        S_OCAP,
        S_OWAIT
    } t_state;

    t_state   r_state, n_state;
    t_cnt     r_count, n_count;
    logic     r_drop,  n_drop;
    t_idx     r_k,     n_k;
    t_idx     r_end,   n_end;
    t_idx     r_last,  n_last;
    t_data    r_carry, n_carry;
    logic     r_out_valid, n_out_valid;
    t_out_req r_out, n_out;

    logic in_acc;
    logic has_room;
    logic gt;
    t_idx last_idx;

    assign in_acc   = i_in_valid && (r_state == S_LOAD);
    assign has_room = r_count < t_cnt'(MAX_ITEMS);
    assign gt       = r_carry > i_rdata;
    assign last_idx = has_room ? r_count[IDX_W-1:0] : t_idx'(MAX_ITEMS - 1);

    // Next-state and store access
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_k         = r_k;
        n_end       = r_end;
        n_last      = r_last;
        n_carry     = r_carry;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_ram       = '0;

        case (r_state)
            S_LOAD: begin
                o_ram.waddr = r_count[IDX_W-1:0];
                o_ram.wdata = i_in_req.value;
                o_ram.raddr = '0;
                if (in_acc) begin
                    o_ram.we = has_room;
                    if (has_room) begin
                        n_count = r_count + t_cnt'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_req.final_item) begin
                        n_last = last_idx;
                        n_end  = last_idx;
                        n_k    = '0;
                        n_state = (last_idx == '0) ? S_ORD : S_PRIME;
                    end
                end
            end
            // rdata holds entry 0; fetch entry 1
            S_PRIME: begin
                n_carry     = i_rdata;
                o_ram.raddr = t_idx'(1);
                n_state     = S_STEP;
            end
            // Compare carry with entry k+1, keep the larger in carry
            S_STEP: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_k;
                o_ram.wdata = gt ? i_rdata : r_carry;
                o_ram.raddr = r_k + t_idx'(2);
                n_carry     = gt ? r_carry : i_rdata;
                if (r_k + t_idx'(1) == r_end) begin
                    n_state = S_TAIL;
                end else begin
                    n_k = r_k + t_idx'(1);
                end
            end
            // Pass maximum lands at the end; start the next pass, or the drain after the last one
            S_TAIL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_end;
                o_ram.wdata = r_carry;
                o_ram.raddr = '0;
                n_end       = r_end - t_idx'(1);
                n_k         = '0;
                n_state     = (r_end == t_idx'(1)) ? S_ORD : S_PRIME;
            end
            S_ORD: begin
                o_ram.raddr = r_k;
                n_state     = S_OCAP;
            end
            S_OCAP: begin
                n_out.sorted_value = i_rdata;
                n_out.run_end      = (r_k == r_last);
                n_out.dropped      = r_drop;
                n_out_valid        = 1'b1;
                n_state            = S_OWAIT;
            end
            // Hold the result until the receiver takes it
            S_OWAIT: begin
                o_ram.raddr = r_k + t_idx'(1);
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out.run_end) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + t_idx'(1);
                        n_state = S_OCAP;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
        r_k     <= n_k;
        r_end   <= n_end;
        r_last  <= n_last;
        r_carry <= n_carry;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

[hw/rtl/bubble_sort_engine_core.sv]
// ============================================================================
// bubble_sort_engine_core
// Loads a set of signed values, bubble sorts it in a local RAM and streams
// the values back in ascending order.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / i_in_req / o_in_stall) takes one element per
//   request; a request with final_item set closes the set. Up to MAX_ITEMS
//   elements are kept; further ones are dropped and flag the whole run.
//   Output channel (o_out_valid / o_out_req / i_out_stall) returns the n
//   stored elements in ascending order, run_end on the last one.
//   While loading, every offered element is taken. After the final request
//   the sort runs n-1 passes over the single-port-read RAM; a pass over e+1
//   entries is one S_PRIME fetch, e S_STEP compares and one S_TAIL write,
//   with one RAM read and one compare per cycle. Each result is drained via
//   S_OCAP and S_OWAIT; a receiver stall holds the result register unchanged.
//   o_in_stall stays high from the final request until run_end is taken.
//   Reset clears the count, the drop flag and the output valid; the store
//   needs no clearing since only written entries are read.
// ============================================================================
module bubble_sort_engine_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bse_pkg::t_in_req  i_in_req,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output bse_pkg::t_out_req o_out_req,
    input  logic              i_out_stall
);
    import bse_pkg::*;

    t_ram_req ram_req;
    t_data    ram_rdata;

    // Sequencer
    bse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    // Element store
    bse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

[hw/rtl/bse_checker.sv]
// ============================================================================
// bse_checker
// Port-level checks of the sort engine, bound to the top level.
// ============================================================================
`include "bubble_sort_engine_core_defines.svh"

module bse_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input bse_pkg::t_in_req  i_in_req,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input bse_pkg::t_out_req o_out_req,
    input logic              i_out_stall
);

    // Stalled result stays offered and unchanged
    `BSE_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `BSE_ASSERT_NXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_req))

    // No loading while results are being drained
    `BSE_ASSERT_IMP(a_no_load_on_drain, o_out_valid, o_in_stall)

    // An accepted final request closes the input
    `BSE_ASSERT_NXT(a_final_closes, i_in_valid && !o_in_stall && i_in_req.final_item,
                    o_in_stall)

    // Nothing follows the last result of a run directly
    `BSE_ASSERT_NXT(a_run_end_gap, o_out_valid && !i_out_stall && o_out_req.run_end,
                    !o_out_valid)

endmodule

bind bubble_sort_engine_core bse_checker u_bse_checker (.*);

[bench/tb_bubble_sort_engine_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_bubble_sort_engine_core
// Self-checking bench for the bubble sort engine. Sets of signed values are
// pushed in as requests, each set closed by a final request. A behavioral
// sorter predicts the ascending stream, the run_end marker and the drop flag
// of each set whose result is not typed in. Returned requests are checked
// in order. Both channels idle and stall at random, with one long receiver
// hold-off and one sender pause until the output has drained.
// ============================================================================
module tb_bubble_sort_engine_core;

    import bse_pkg::*;

    localparam t_data VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam int    N_ITEMS = 480;

    // One offered request plus an optional hand-typed result
    typedef struct packed {
        t_in_req req;
        logic    typed;
        t_data   exp_value;
    } t_row;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_req   i_in_req    = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_req  o_out_req;
    logic      i_out_stall = 1'b0;

    // Behavioral sorter state
    t_data     stash [MAX_ITEMS];
    int        stash_cnt  = 0;
    logic      stash_drop = 1'b0;
    t_out_req  sorted_batch [$];

    t_out_req  pending_sorted [$];
    t_row      offered_rows [$];
    t_row      dir_rows [$];

    int        errors      = 0;
    int        items_sent  = 0;
    int        taken_count = 0;
    int        send_calm   = 0;
    int        recv_calm   = 0;
    logic      held_long   = 1'b0;

    bubble_sort_engine_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("tb_bubble_sort_engine_core NOT OK");
        $finish;
    end

    // Idle cycles before a handshake; occasional runs of back-to-back traffic
    function automatic int pick_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 16);
    endfunction

    function automatic t_row mk_row(t_data v, logic fin, logic typed, t_data ev);
        t_row r;
        r.req.value      = v;
        r.req.final_item = fin;
        r.typed          = typed;
        r.exp_value      = ev;
        return r;
    endfunction

    // Mix of extremes, near-zero duplicates and full-range values
    function automatic t_data pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return t_data'($urandom_range(0, 8)) - t_data'(4);
            default: return t_data'($urandom());
        endcase
    endfunction

    // Mostly short sets, a few full and overfull ones
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 90)
            return $urandom_range(9, 32);
        else if (r < 97)
            return $urandom_range(33, 64);
        else
            return $urandom_range(65, 70);
    endfunction

    // Predict the results caused by one accepted request
    task automatic sort_model_accept(input t_in_req r);
        t_data    tmp;
        t_out_req res;
        sorted_batch.delete();
        if (stash_cnt < MAX_ITEMS) begin
            stash[stash_cnt] = r.value;
            stash_cnt++;
        end else begin
            stash_drop = 1'b1;
        end
        if (r.final_item) begin
            // adjacent compare-and-swap, strict greater only (stable)
            for (int p = 1; p < stash_cnt; p++) begin
                for (int k = 0; k + p < stash_cnt; k++) begin
                    if (stash[k] > stash[k+1]) begin
                        tmp        = stash[k];
                        stash[k]   = stash[k+1];
                        stash[k+1] = tmp;
                    end
                end
            end
            for (int k = 0; k < stash_cnt; k++) begin
                res.sorted_value = stash[k];
                res.run_end      = (k == stash_cnt - 1);
                res.dropped      = stash_drop;
                sorted_batch.push_back(res);
            end
            stash_cnt  = 0;
            stash_drop = 1'b0;
        end
    endtask

    // Input request accepted: queue what it should produce
    task automatic take_request();
        t_row     row;
        t_out_req typed_res;
        row = offered_rows.pop_front();
        sort_model_accept(i_in_req);
        if (row.typed) begin
            typed_res.sorted_value = row.exp_value;
            typed_res.run_end      = 1'b1;
            typed_res.dropped      = 1'b0;
            pending_sorted.push_back(typed_res);
        end else begin
            foreach (sorted_batch[k])
                pending_sorted.push_back(sorted_batch[k]);
        end
    endtask

    // Output request accepted: compare with the oldest expectation
    task automatic check_result(input t_out_req got);
        t_out_req want;
        if (pending_sorted.size() == 0) begin
            $display("%0t: unexpected result value %0d run_end %b dropped %b",
                     $time, got.sorted_value, got.run_end, got.dropped);
            errors++;
        end else begin
            want = pending_sorted.pop_front();
            if (got.sorted_value !== want.sorted_value || got.run_end !== want.run_end ||
                got.dropped !== want.dropped) begin
                $display("%0t: expected value %0d run_end %b dropped %b, got %0d %b %b",
                         $time, want.sorted_value, want.run_end, want.dropped,
                         got.sorted_value, got.run_end, got.dropped);
                errors++;
            end
        end
    endtask

    // Handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_result(o_out_req);
            if (i_in_valid && !o_in_stall)
                take_request();
        end
    end

    // Offer one request and hold it until accepted; valid is left high
    task automatic send_row(input t_row row);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= row.req;
        offered_rows.push_back(row);
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_row(mk_row(pick_value(), (i == len - 1), 1'b0, '0));
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain_output();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sorted.size() != 0 || offered_rows.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: random stalls, one long hold-off while the sender keeps going
    initial begin
        int wait_cycles;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            wait_cycles = pick_gap(recv_calm);
            if (!held_long && taken_count >= 40) begin
                held_long   = 1'b1;
                wait_cycles = 600;
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            taken_count++;
        end
    end

    // Reset and stimulus
    initial begin
        logic paused;
        paused = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-value sets: result is the value itself
        dir_rows.push_back(mk_row(VAL_MAX, 1'b1, 1'b1, VAL_MAX));
        dir_rows.push_back(mk_row(VAL_MIN, 1'b1, 1'b1, VAL_MIN));
        dir_rows.push_back(mk_row('0,      1'b1, 1'b1, '0));
        dir_rows.push_back(mk_row('1,      1'b1, 1'b1, '1));
        // mixed extremes
        dir_rows.push_back(mk_row(t_data'(5),  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(-t_data'(3), 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(VAL_MAX,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(VAL_MIN,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row('0,          1'b1, 1'b0, '0));
        // equal values are never swapped
        dir_rows.push_back(mk_row(t_data'(7),  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(t_data'(7),  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(-t_data'(2), 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(t_data'(7),  1'b1, 1'b0, '0));
        // descending input, worst case swapping
        dir_rows.push_back(mk_row(t_data'(3),  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(t_data'(2),  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(t_data'(1),  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row('0,          1'b1, 1'b0, '0));
        // already sorted pair, alternating bit patterns
        dir_rows.push_back(mk_row(-t_data'(100), 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(t_data'(100),  1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row(t_data'(32'hAAAAAAAA), 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(t_data'(32'h55555555), 1'b1, 1'b0, '0));
        foreach (dir_rows[i])
            send_row(dir_rows[i]);

        // exactly full store, then overfull with the final request dropped
        send_run(MAX_ITEMS);
        send_run(MAX_ITEMS + 2);

        // random sets
        while (items_sent < N_ITEMS) begin
            if (!paused && items_sent >= 250) begin
                paused = 1'b1;
                drain_output();
            end
            send_run(pick_len());
        end

        drain_output();
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb_bubble_sort_engine_core OK");
        else
            $display("tb_bubble_sort_engine_core NOT OK");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bse_pkg.sv
hw/rtl/bse_ram.sv
hw/rtl/bse_ctrl.sv
hw/rtl/bubble_sort_engine_core.sv
hw/rtl/bse_checker.sv
bench/tb_bubble_sort_engine_core.sv
